// ===== hdl/dtq_pkg.sv =====
package dtq_pkg;

  localparam int DELAY_W = 24;
  localparam int TPM_W   = 16;
  localparam int TAG_W   = 8;
  localparam int STAMP_W = 16;
  localparam int SPAN_W  = DELAY_W + TPM_W;

  localparam logic [TPM_W-1:0] TPM_RESET = TPM_W'(1000);

  localparam int DEF_HEAP_DEPTH = 16;
  localparam int DEF_TIME_BITS  = 48;

  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_CREATE = 1'b1;

  typedef struct packed {
    logic               command;
    logic [DELAY_W-1:0] delay_ms;
    logic [TAG_W-1:0]   tag;
  } in_t;

  typedef struct packed {
    logic             fired;
    logic [TAG_W-1:0] fired_tag;
    logic             rejected;
    logic             last;
  } out_t;

endpackage

// ===== hdl/dtq_cmp.sv =====
module dtq_cmp
  import dtq_pkg::*;
#(
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic [TIME_BITS-1:0] a_deadline,
  input  logic [STAMP_W-1:0]   a_stamp,
  input  logic [TIME_BITS-1:0] b_deadline,
  input  logic [STAMP_W-1:0]   b_stamp,
  input  logic                 tie_ok,
  output logic                 a_first
);

  logic dl_lt;
  logic dl_eq;
  logic st_lt;

  assign dl_lt = a_deadline < b_deadline;
  assign dl_eq = a_deadline == b_deadline;
  assign st_lt = a_stamp < b_stamp;

  // With tie_ok set, equal deadlines count as "first" and stamps are ignored.
  assign a_first = dl_lt || (dl_eq && (tie_ok || st_lt));

endmodule

// ===== hdl/deadline_timer_queue.sv =====
// One-shot timer queue built on a binary min-heap held in a small memory.
// Input channel (in_valid/in_ready/in_data): a tick request advances the
// time counter by one, a create request arms a timer at now plus
// delay_ms * ticks_per_ms (saturating at the largest time value).
// Result channel (out_valid/out_ready/out_data): every request gives one
// result per expired timer, earliest deadline first, ties in creation order,
// or one empty result when nothing expires; the final one carries last.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) writes ticks_per_ms
// and is always ready; write it only while the queue is idle.
// Timing: in_ready is high only while the sequencer is idle, so one request
// is in flight at a time. With nothing due a tick passes S_CHK_RD and S_CHK_CMP
// (S_CHK_RD alone when the queue is empty). A create adds S_MUL, S_ADD and
// S_UP_RD, plus S_UP_CMP and S_UP_RD per heap level climbed. An expired timer
// adds S_CHK_CMP and S_CHK_RD, and unless it empties the queue the pop states
// and S_DN_RDL to S_DN_MOVE for each heap level the sift-down visits. This
// order comes from the one heap memory read port and the single shared comparator.
// A stalled receiver holds the sequencer on its next result; one finished
// result waits in the output register meanwhile.
// Reset empties the queue, clears time and the creation stamp and loads
// ticks_per_ms with 1000. No clearing pass is needed.
module deadline_timer_queue
  import dtq_pkg::*;
#(
  parameter int HEAP_DEPTH = DEF_HEAP_DEPTH,
  parameter int TIME_BITS  = DEF_TIME_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [TPM_W-1:0] cfg_data
);

  localparam int IDX_W   = $clog2(HEAP_DEPTH);
  localparam int CNT_W   = $clog2(HEAP_DEPTH + 1);
  localparam int CH_W    = IDX_W + 1;
  localparam int ENTRY_W = TIME_BITS + TAG_W + STAMP_W;
  localparam int SUM_W   = ((TIME_BITS > SPAN_W) ? TIME_BITS : SPAN_W) + 1;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MUL     = 4'd1;
  localparam logic [3:0] S_ADD     = 4'd2;
  localparam logic [3:0] S_UP_RD   = 4'd3;
  localparam logic [3:0] S_UP_CMP  = 4'd4;
  localparam logic [3:0] S_CHK_RD  = 4'd5;
  localparam logic [3:0] S_CHK_CMP = 4'd6;
  localparam logic [3:0] S_POP_RD  = 4'd7;
  localparam logic [3:0] S_POP_LD  = 4'd8;
  localparam logic [3:0] S_DN_RDL  = 4'd9;
  localparam logic [3:0] S_DN_CMPL = 4'd10;
  localparam logic [3:0] S_DN_CMPR = 4'd11;
  localparam logic [3:0] S_DN_MOVE = 4'd12;

  logic [3:0]           state_r, state_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [STAMP_W-1:0]   stamp_r, stamp_nxt;
  logic [TPM_W-1:0]     tpm_r, tpm_nxt;
  in_t                  item_r, item_nxt;
  logic                 rej_r, rej_nxt;
  logic [SPAN_W-1:0]    span_r, span_nxt;
  logic [ENTRY_W-1:0]   hold_r, hold_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [ENTRY_W-1:0]   best_r, best_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  logic                 best_child_r, best_child_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  logic [TAG_W-1:0]     pend_tag_r, pend_tag_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_data_r, out_data_nxt;

  logic [ENTRY_W-1:0] heap_mem [HEAP_DEPTH];
  logic [ENTRY_W-1:0] mem_rd_r;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [IDX_W-1:0]   rd_addr;

  logic [ENTRY_W-1:0] cmp_a;
  logic [ENTRY_W-1:0] cmp_b;
  logic               cmp_tie;
  logic               a_first;

  logic                 out_free;
  logic                 emit;
  out_t                 emit_data;
  logic                 heap_full;
  logic [IDX_W-1:0]     parent_idx;
  logic [CH_W-1:0]      left_idx;
  logic [CH_W-1:0]      right_idx;
  logic [SUM_W-1:0]     dl_sum;
  logic [TIME_BITS-1:0] dl_value;
  logic [ENTRY_W-1:0]   now_entry;

  assign in_ready  = state_r == S_IDLE;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign out_free   = !out_valid_r || out_ready;
  assign heap_full  = count_r == CNT_W'(HEAP_DEPTH);
  assign parent_idx = (idx_r - IDX_W'(1)) >> 1;
  assign left_idx   = {idx_r, 1'b1};
  assign right_idx  = left_idx + CH_W'(1);
  assign now_entry  = {now_r, {TAG_W{1'b0}}, {STAMP_W{1'b0}}};

  // A carry into any bit above the time width means the deadline saturates.
  assign dl_sum   = SUM_W'(now_r) + SUM_W'(span_r);
  assign dl_value = (|dl_sum[SUM_W-1:TIME_BITS]) ? {TIME_BITS{1'b1}}
                                                 : dl_sum[TIME_BITS-1:0];

  dtq_cmp #(
    .TIME_BITS (TIME_BITS)
  ) u_cmp (
    .a_deadline (cmp_a[ENTRY_W-1 -: TIME_BITS]),
    .a_stamp    (cmp_a[STAMP_W-1:0]),
    .b_deadline (cmp_b[ENTRY_W-1 -: TIME_BITS]),
    .b_stamp    (cmp_b[STAMP_W-1:0]),
    .tie_ok     (cmp_tie),
    .a_first    (a_first)
  );

  always_comb begin
    state_nxt      = state_r;
    now_nxt        = now_r;
    count_nxt      = count_r;
    stamp_nxt      = stamp_r;
    tpm_nxt        = tpm_r;
    item_nxt       = item_r;
    rej_nxt        = rej_r;
    span_nxt       = span_r;
    hold_nxt       = hold_r;
    idx_nxt        = idx_r;
    best_nxt       = best_r;
    best_idx_nxt   = best_idx_r;
    best_child_nxt = best_child_r;
    pend_valid_nxt = pend_valid_r;
    pend_tag_nxt   = pend_tag_r;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = hold_r;
    rd_addr        = '0;
    cmp_a          = mem_rd_r;
    cmp_b          = hold_r;
    cmp_tie        = 1'b0;
    emit           = 1'b0;
    emit_data      = '0;

    if (cfg_valid) begin
      tpm_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt       = in_data;
          rej_nxt        = 1'b0;
          pend_valid_nxt = 1'b0;
          if (in_data.command == CMD_TICK) begin
            now_nxt   = now_r + TIME_BITS'(1);
            state_nxt = S_CHK_RD;
          end else if (heap_full) begin
            rej_nxt   = 1'b1;
            state_nxt = S_CHK_RD;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        span_nxt  = SPAN_W'(item_r.delay_ms) * SPAN_W'(tpm_r);
        state_nxt = S_ADD;
      end
      S_ADD: begin
        hold_nxt  = {dl_value, item_r.tag, stamp_r};
        stamp_nxt = stamp_r + STAMP_W'(1);
        idx_nxt   = count_r[IDX_W-1:0];
        count_nxt = count_r + CNT_W'(1);
        state_nxt = S_UP_RD;
      end
      S_UP_RD: begin
        if (idx_r == '0) begin
          wr_en     = 1'b1;
          state_nxt = S_CHK_RD;
        end else begin
          rd_addr   = parent_idx;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        // The new timer travels up in hold_r; a later parent moves down.
        cmp_a = hold_r;
        cmp_b = mem_rd_r;
        wr_en = 1'b1;
        if (a_first) begin
          wr_data   = mem_rd_r;
          idx_nxt   = parent_idx;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_CHK_RD;
        end
      end
      S_CHK_RD: begin
        if (count_r == '0) begin
          if (out_free) begin
            emit           = 1'b1;
            emit_data      = '{fired: pend_valid_r,
                               fired_tag: pend_valid_r ? pend_tag_r : '0,
                               rejected: rej_r, last: 1'b1};
            pend_valid_nxt = 1'b0;
            state_nxt      = S_IDLE;
          end
        end else begin
          state_nxt = S_CHK_CMP;
        end
      end
      S_CHK_CMP: begin
        // The previous firing is held back until we know whether it is the last.
        cmp_b   = now_entry;
        cmp_tie = 1'b1;
        if (a_first) begin
          if (!pend_valid_r || out_free) begin
            if (pend_valid_r) begin
              emit      = 1'b1;
              emit_data = '{fired: 1'b1, fired_tag: pend_tag_r,
                            rejected: rej_r, last: 1'b0};
            end
            pend_valid_nxt = 1'b1;
            pend_tag_nxt   = mem_rd_r[STAMP_W +: TAG_W];
            count_nxt      = count_r - CNT_W'(1);
            state_nxt      = (count_r == CNT_W'(1)) ? S_CHK_RD : S_POP_RD;
          end
        end else if (out_free) begin
          emit           = 1'b1;
          emit_data      = '{fired: pend_valid_r,
                             fired_tag: pend_valid_r ? pend_tag_r : '0,
                             rejected: rej_r, last: 1'b1};
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      S_POP_RD: begin
        rd_addr   = count_r[IDX_W-1:0];
        state_nxt = S_POP_LD;
      end
      S_POP_LD: begin
        hold_nxt  = mem_rd_r;
        idx_nxt   = '0;
        state_nxt = S_DN_RDL;
      end
      S_DN_RDL: begin
        if (left_idx >= CH_W'(count_r)) begin
          wr_en     = 1'b1;
          state_nxt = S_CHK_RD;
        end else begin
          rd_addr   = left_idx[IDX_W-1:0];
          state_nxt = S_DN_CMPL;
        end
      end
      S_DN_CMPL: begin
        if (a_first) begin
          best_nxt       = mem_rd_r;
          best_idx_nxt   = left_idx[IDX_W-1:0];
          best_child_nxt = 1'b1;
        end else begin
          best_nxt       = hold_r;
          best_child_nxt = 1'b0;
        end
        if (right_idx < CH_W'(count_r)) begin
          rd_addr   = right_idx[IDX_W-1:0];
          state_nxt = S_DN_CMPR;
        end else begin
          state_nxt = S_DN_MOVE;
        end
      end
      S_DN_CMPR: begin
        cmp_b = best_r;
        if (a_first) begin
          best_nxt       = mem_rd_r;
          best_idx_nxt   = right_idx[IDX_W-1:0];
          best_child_nxt = 1'b1;
        end
        state_nxt = S_DN_MOVE;
      end
      S_DN_MOVE: begin
        wr_en = 1'b1;
        if (best_child_r) begin
          wr_data   = best_r;
          idx_nxt   = best_idx_r;
          state_nxt = S_DN_RDL;
        end else begin
          state_nxt = S_CHK_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_data_nxt = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit_data;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      now_r        <= '0;
      count_r      <= '0;
      stamp_r      <= '0;
      tpm_r        <= TPM_RESET;
      rej_r        <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      now_r        <= now_nxt;
      count_r      <= count_nxt;
      stamp_r      <= stamp_nxt;
      tpm_r        <= tpm_nxt;
      rej_r        <= rej_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    span_r       <= span_nxt;
    hold_r       <= hold_nxt;
    idx_r        <= idx_nxt;
    best_r       <= best_nxt;
    best_idx_r   <= best_idx_nxt;
    best_child_r <= best_child_nxt;
    pend_tag_r   <= pend_tag_nxt;
    out_data_r   <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    mem_rd_r <= heap_mem[rd_addr];
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(HEAP_DEPTH))
    else $error("timer count exceeds heap depth");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_valid_r)
    else $error("firing left pending while idle");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.fired |-> out_data_r.last && out_data_r.fired_tag == '0)
    else $error("empty result not final or carries a tag");

  a_idle_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |=> count_r == $past(count_r))
    else $error("timer count changed on request acceptance");

  a_insert_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ADD |-> !heap_full)
    else $error("insert started on a full heap");

endmodule
